// ----- hdl/dqs_pkg.sv -----
// ---------------------------------------------------------------------------
// dqs_pkg: shared types and codes for the double-ended queue
// Field widths, command and status codes, and the result word layout.
// ---------------------------------------------------------------------------
package dqs_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 7;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // one result word
  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     found;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         occupancy;
  } result_t;

endpackage

// ----- hdl/dqs_if.sv -----
// ---------------------------------------------------------------------------
// dqs interfaces: command and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface dqs_item_if;
  logic                                valid;
  logic                                ready;
  logic [dqs_pkg::CMD_W-1:0]           command;
  logic signed [dqs_pkg::DATA_W-1:0]   value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface dqs_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [dqs_pkg::DATA_W-1:0]   popped_value;
  logic                                found;
  logic [dqs_pkg::STAT_W-1:0]          status;
  logic [dqs_pkg::OCC_W-1:0]           occupancy;

  modport source (output valid, popped_value, found, status, occupancy, input ready);
  modport sink   (input valid, popped_value, found, status, occupancy, output ready);
endinterface

// ----- hdl/dqs_ram.sv -----
// ---------------------------------------------------------------------------
// dqs_ram: generic memory, one write port and two registered read ports
// Read data appears in the cycle after the address is presented.
// ---------------------------------------------------------------------------
module dqs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  output logic [Width-1:0] rdata_a_o,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- hdl/double_ended_queue_with_search.sv -----
// Results: push, failed pop, empty search and unused codes pass their result to the output register
//   (or the holding slot when it is busy); a pop first reads the memory, then passes the word on in ST_POP.
// Search reads both ends of the ring at once through the two memory read ports,
//   walking inward from both ends and stopping early when the key hits.
// Throughput: one command at a time; pushes run at one per cycle while the result holding slot is free.
// Reset: queue empty, front at entry 0; memory contents stay undefined until written.
// ---------------------------------------------------------------------------
// double_ended_queue_with_search: bounded deque in a ring memory with key search
// Front pointer and count live in registers, words in a two-read-port RAM.
// ---------------------------------------------------------------------------
module double_ended_queue_with_search #(
  parameter int unsigned DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dqs_item_if.sink       item_i,
  dqs_result_if.source   result_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SRCH
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          front_q, front_d;
  logic [CW-1:0]          count_q, count_d;
  logic [dqs_pkg::DATA_W-1:0] key_q, key_d;
  logic [AW-1:0]          ra_q, ra_d;
  logic [AW-1:0]          rb_q, rb_d;
  logic [CW-1:0]          left_q, left_d;
  logic                   chk_q, chk_d;
  logic                   out_valid_q, out_valid_d;
  dqs_pkg::result_t       out_res_q, out_res_d;
  logic                   hold_valid_q, hold_valid_d;
  dqs_pkg::result_t       hold_res_q, hold_res_d;

  logic                   accept;
  logic                   out_take, out_free;
  logic                   done;
  dqs_pkg::result_t       done_res;
  logic                   is_empty, is_full;
  logic [AW-1:0]          front_dec, front_inc, tail_idx, back_idx;
  logic [SW-1:0]          tail_sum, back_sum;
  logic                   we;
  logic [AW-1:0]          waddr, raddr_a;
  logic [dqs_pkg::DATA_W-1:0] rdata_a, rdata_b;
  logic                   hit;

  assign accept   = item_i.valid && item_i.ready;
  assign out_take = out_valid_q && result_o.ready;
  assign out_free = !out_valid_q || out_take;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q >= DEPTH_C);

  // ring positions around the front pointer
  assign front_dec = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
  assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + AW'(1);
  assign tail_sum  = SW'(front_q) + SW'(count_q);
  assign tail_idx  = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign back_sum  = tail_sum - SW'(1);
  assign back_idx  = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);

  // memory write on a push with room
  assign we    = accept && !is_full &&
                 (item_i.command == dqs_pkg::CMD_PUSH_FRONT ||
                  item_i.command == dqs_pkg::CMD_PUSH_BACK);
  assign waddr = (item_i.command == dqs_pkg::CMD_PUSH_FRONT) ? front_dec : tail_idx;

  // port a serves pops when idle and the front-side walk during search
  assign raddr_a = (state_q == ST_SRCH) ? ra_q :
                   (item_i.command == dqs_pkg::CMD_POP_BACK) ? back_idx : front_q;

  dqs_ram #(
    .Width (dqs_pkg::DATA_W),
    .Depth (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (item_i.value),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (rb_q),
    .rdata_b_o (rdata_b)
  );

  assign hit = (rdata_a == key_q) || (rdata_b == key_q);

  assign item_i.ready = (state_q == ST_IDLE) && !hold_valid_q;

  // command sequencer
  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    count_d  = count_q;
    key_d    = key_q;
    ra_d     = ra_q;
    rb_d     = rb_q;
    left_d   = left_q;
    chk_d    = 1'b0;
    done     = 1'b0;
    done_res = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_i.command)
            dqs_pkg::CMD_PUSH_FRONT: begin
              done = 1'b1;
              if (is_full) begin
                done_res.status = dqs_pkg::STAT_FULL;
              end else begin
                front_d = front_dec;
                count_d = count_q + CW'(1);
              end
            end
            dqs_pkg::CMD_PUSH_BACK: begin
              done = 1'b1;
              if (is_full) begin
                done_res.status = dqs_pkg::STAT_FULL;
              end else begin
                count_d = count_q + CW'(1);
              end
            end
            dqs_pkg::CMD_POP_FRONT: begin
              if (is_empty) begin
                done            = 1'b1;
                done_res.status = dqs_pkg::STAT_EMPTY;
              end else begin
                front_d = front_inc;
                count_d = count_q - CW'(1);
                state_d = ST_POP;
              end
            end
            dqs_pkg::CMD_POP_BACK: begin
              if (is_empty) begin
                done            = 1'b1;
                done_res.status = dqs_pkg::STAT_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                state_d = ST_POP;
              end
            end
            dqs_pkg::CMD_SEARCH: begin
              if (is_empty) begin
                done = 1'b1;
              end else begin
                key_d   = item_i.value;
                ra_d    = front_q;
                rb_d    = back_idx;
                left_d  = CW'((SW'(count_q) + SW'(1)) >> 1);
                state_d = ST_SRCH;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
          done_res.occupancy = dqs_pkg::OCC_W'(count_d);
        end
      end
      ST_POP: begin
        done                  = 1'b1;
        done_res.popped_value = rdata_a;
        done_res.occupancy    = dqs_pkg::OCC_W'(count_q);
        state_d               = ST_IDLE;
      end
      ST_SRCH: begin
        // issue one read at each end, compare the pair read last cycle
        if (left_q != '0) begin
          chk_d  = 1'b1;
          left_d = left_q - CW'(1);
          ra_d   = (ra_q == LAST_IDX) ? '0 : ra_q + AW'(1);
          rb_d   = (rb_q == '0) ? LAST_IDX : rb_q - AW'(1);
        end
        if (chk_q && (hit || left_q == '0)) begin
          done               = 1'b1;
          done_res.found     = hit;
          done_res.occupancy = dqs_pkg::OCC_W'(count_q);
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register with one holding slot behind it
  always_comb begin
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    hold_valid_d = hold_valid_q;
    hold_res_d   = hold_res_q;
    if (done) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_res_d   = done_res;
      end else begin
        hold_valid_d = 1'b1;
        hold_res_d   = done_res;
      end
    end else if (hold_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_res_d    = hold_res_q;
      hold_valid_d = 1'b0;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      front_q      <= '0;
      count_q      <= '0;
      left_q       <= '0;
      chk_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      front_q      <= front_d;
      count_q      <= count_d;
      left_q       <= left_d;
      chk_q        <= chk_d;
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    out_res_q  <= out_res_d;
    hold_res_q <= hold_res_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.popped_value = out_res_q.popped_value;
  assign result_o.found        = out_res_q.found;
  assign result_o.status       = out_res_q.status;
  assign result_o.occupancy    = out_res_q.occupancy;

endmodule
